// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition must never be seen at a rising edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

// ===== sv/ipwd_pkg.sv =====
// Shared types and constants of the IR pulse width decoder
package ipwd_pkg;

  localparam int unsigned TICK_W    = 8;
  localparam int unsigned CODE_W    = 12;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TO = 2'd2;

  // register reset values
  localparam logic [TICK_W-1:0] RST_ONE_MIN  = 8'd11;
  localparam logic [TICK_W-1:0] RST_ONE_MAX  = 8'd16;
  localparam logic [TICK_W-1:0] RST_FRAME_TO = 8'd50;

  // input commands
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_EDGE = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] one_min;
    logic [TICK_W-1:0] one_max;
    logic [TICK_W-1:0] frame_to;
  } cfg_t;

endpackage

// ===== sv/ipwd_cfg_regs.sv =====
// Configuration register file of the IR pulse width decoder
module ipwd_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipwd_pkg::TICK_W-1:0]     cfg_data,
  output ipwd_pkg::cfg_t                  cfg
);

  ipwd_pkg::cfg_t cfg_r, cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        ipwd_pkg::REG_ONE_MIN:  cfg_nxt.one_min  = cfg_data;
        ipwd_pkg::REG_ONE_MAX:  cfg_nxt.one_max  = cfg_data;
        ipwd_pkg::REG_FRAME_TO: cfg_nxt.frame_to = cfg_data;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.one_min  <= ipwd_pkg::RST_ONE_MIN;
      cfg_r.one_max  <= ipwd_pkg::RST_ONE_MAX;
      cfg_r.frame_to <= ipwd_pkg::RST_FRAME_TO;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== sv/ipwd_core.sv =====
// Pulse width capture, frame timeout and window decode
`include "assert_macros.svh"

module ipwd_core #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_valid,
  input  logic                         step_cmd,
  input  logic                         step_level,
  input  ipwd_pkg::cfg_t               cfg,
  output logic                         res_valid,
  output logic [ipwd_pkg::CODE_W-1:0]  res_code
);

  localparam int unsigned IDX_W = $clog2(CODE_BITS + 1);
  localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(CODE_BITS);

  logic [ipwd_pkg::TICK_W-1:0] low_ticks_r, low_ticks_nxt;
  logic [ipwd_pkg::TICK_W-1:0] timeout_left_r, timeout_left_nxt;
  logic [IDX_W-1:0]            width_idx_r, width_idx_nxt;
  logic [ipwd_pkg::TICK_W-1:0] widths_r   [CODE_BITS];
  logic [ipwd_pkg::TICK_W-1:0] widths_nxt [CODE_BITS];

  logic [CODE_BITS-1:0]                 hits;
  logic [CODE_BITS+ipwd_pkg::CODE_W-1:0] hits_ext;
  logic                                 is_tick, is_fall, is_rise;

  assign is_tick = step_valid && (step_cmd == ipwd_pkg::CMD_TICK);
  assign is_fall = step_valid && (step_cmd == ipwd_pkg::CMD_EDGE) && !step_level;
  assign is_rise = step_valid && (step_cmd == ipwd_pkg::CMD_EDGE) && step_level;

  // parallel window compare over every stored width
  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      hits[i] = (widths_r[i] >= cfg.one_min) && (widths_r[i] <= cfg.one_max);
    end
  end

  // bits past the code width are dropped, missing ones read as zero
  assign hits_ext  = {{ipwd_pkg::CODE_W{1'b0}}, hits};
  assign res_code  = hits_ext[ipwd_pkg::CODE_W-1:0];
  assign res_valid = is_tick && (timeout_left_r == ipwd_pkg::TICK_W'(1));

  always_comb begin
    low_ticks_nxt    = low_ticks_r;
    timeout_left_nxt = timeout_left_r;
    width_idx_nxt    = width_idx_r;
    for (int i = 0; i < CODE_BITS; i++) begin
      widths_nxt[i] = widths_r[i];
    end

    if (is_tick) begin
      if (low_ticks_r != ipwd_pkg::TICK_MAX) begin
        low_ticks_nxt = low_ticks_r + ipwd_pkg::TICK_W'(1);
      end
      if (timeout_left_r != '0) begin
        timeout_left_nxt = timeout_left_r - ipwd_pkg::TICK_W'(1);
      end
    end else if (is_fall) begin
      // new frame restarts the store
      if (timeout_left_r == '0) begin
        width_idx_nxt = '0;
      end
      low_ticks_nxt    = '0;
      timeout_left_nxt = cfg.frame_to;
    end else if (is_rise) begin
      if (width_idx_r < IDX_FULL) begin
        for (int i = 0; i < CODE_BITS; i++) begin
          if (width_idx_r == IDX_W'(i)) begin
            widths_nxt[i] = low_ticks_r;
          end
        end
        width_idx_nxt = width_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_ticks_r    <= '0;
      timeout_left_r <= '0;
      width_idx_r    <= '0;
      for (int i = 0; i < CODE_BITS; i++) begin
        widths_r[i] <= '0;
      end
    end else begin
      low_ticks_r    <= low_ticks_nxt;
      timeout_left_r <= timeout_left_nxt;
      width_idx_r    <= width_idx_nxt;
      for (int i = 0; i < CODE_BITS; i++) begin
        widths_r[i] <= widths_nxt[i];
      end
    end
  end

  `ASSERT_CLK(a_idx_bound, clk, rst_n, width_idx_r <= IDX_FULL, "store index past end")
  `ASSERT_CLK(a_res_ends_frame, clk, rst_n, res_valid |=> timeout_left_r == '0, "frame still running after decode")
  `ASSERT_NEVER(a_res_only_tick, clk, rst_n, res_valid && !is_tick, "decode on a non-tick beat")

endmodule

// ===== sv/ipwd_out_buf.sv =====
// Result register with skid entry
`include "assert_macros.svh"

module ipwd_out_buf (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [ipwd_pkg::CODE_W-1:0]  push_code,
  output logic                         full,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [ipwd_pkg::CODE_W-1:0]  out_code
);

  logic                        out_valid_r, out_valid_nxt;
  logic                        skid_valid_r, skid_valid_nxt;
  logic [ipwd_pkg::CODE_W-1:0] out_code_r, out_code_nxt;
  logic [ipwd_pkg::CODE_W-1:0] skid_code_r, skid_code_nxt;
  logic                        pop;

  assign pop       = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_code  = out_code_r;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_code_nxt   = out_code_r;
    skid_code_nxt  = skid_code_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_code_nxt   = skid_code_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_code_nxt  = push_code;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_code_nxt  = push_code;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_code_r  <= out_code_nxt;
    skid_code_r <= skid_code_nxt;
  end

  `ASSERT_CLK(a_skid_behind_out, clk, rst_n, skid_valid_r |-> out_valid_r, "skid holds a beat ahead of an empty output")
  `ASSERT_NEVER(a_no_overflow, clk, rst_n, push && skid_valid_r, "result pushed into a full buffer")

endmodule

// ===== sv/ir_pulse_width_decoder.sv =====
// A beat waits in the input register; its code then enters the result register or skid entry.
// Throughput: one input beat per cycle, unless the skid entry is full with a beat held.
// Ticks decrement the frame timeout; the decode fires on the tick that takes it from one to zero.
// Reset (rst_n low, synchronous): counters, store index and all stored widths go to zero,
// registers to their defaults (window 11..16, timeout 50); input and result stages empty.
module ir_pulse_width_decoder #(
  parameter int unsigned CODE_BITS = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_cmd,
  input  logic                            in_level,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [ipwd_pkg::CODE_W-1:0]     out_code,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipwd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipwd_pkg::TICK_W-1:0]     cfg_data
);

  ipwd_pkg::cfg_t              cfg;
  logic                        in_valid_r, in_valid_nxt;
  logic                        in_cmd_r, in_level_r;
  logic                        buf_full;
  logic                        advance;
  logic                        in_accept;
  logic                        res_valid;
  logic [ipwd_pkg::CODE_W-1:0] res_code;

  // The held beat moves on whenever the skid entry is free: the buffer then
  // has room for at least one more result, and one beat makes at most one.
  assign advance   = in_valid_r && !buf_full;
  assign in_stall  = in_valid_r && buf_full;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // input register: control cleared on reset, payload loaded on accept and never reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
    if (in_accept) begin
      in_cmd_r   <= in_cmd;
      in_level_r <= in_level;
    end
  end

  ipwd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update and decode for the held beat
  ipwd_core #(
    .CODE_BITS (CODE_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (advance),
    .step_cmd   (in_cmd_r),
    .step_level (in_level_r),
    .cfg        (cfg),
    .res_valid  (res_valid),
    .res_code   (res_code)
  );

  ipwd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_code (res_code),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_code  (out_code)
  );

endmodule
